// File: rtl/core/mts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants of the melody tone sequencer
// Transaction structs, operation codes, note memory geometry and the
// struct types that pass between the sequencer, divider and note memory.
// ----------------------------------------------------------------------------
package mts_pkg;

    // Note memory geometry (depth is a power of two)
    localparam int NOTE_DEPTH = 64;
    localparam int AW         = $clog2(NOTE_DEPTH);

    // Timer input clock of the buzzer
    localparam int CLOCK_HZ   = 1000000;
    localparam int CLK_W      = $clog2(CLOCK_HZ + 1);
    localparam int CNT_W      = $clog2(CLK_W);

    // Divisor 16*freq fits 20 bits
    localparam int DEN_W      = 20;

    // Operation codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;
    localparam logic [1:0] OP_TOGGLE = 2'd3;

    // Input transaction
    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  note_address;
        logic [15:0] note_frequency;
        logic [15:0] note_duration;
    } t_mts_in;

    // Output transaction
    typedef struct packed {
        logic        tone_on;
        logic [7:0]  compare_divider;
        logic        playing;
        logic        buzz_enable;
        logic [5:0]  current_note;
    } t_mts_out;

    // Note memory write port
    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        logic [31:0]   data;
    } t_mts_mem_wr;

    // Divider request and response
    typedef struct packed {
        logic        start;
        logic [15:0] freq;
    } t_mts_div_req;

    typedef struct packed {
        logic       done;
        logic [7:0] divider;
    } t_mts_div_rsp;

    // Map a 6-bit address field onto the memory address range
    function automatic logic [AW-1:0] mts_addr(input logic [5:0] a);
        logic [AW+5:0] t;
        t = {{AW{1'b0}}, a};
        return t[AW-1:0];
    endfunction

    // Report a memory pointer in the 6-bit current_note field
    function automatic logic [5:0] mts_note_field(input logic [AW-1:0] p);
        logic [AW+5:0] t;
        t = {6'd0, p};
        return t[5:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/mts_note_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mts_note_mem: note memory
// One write port and one read port with registered read data.
// Entries are frequency[31:16], duration[15:0].
// ----------------------------------------------------------------------------
module mts_note_mem
    import mts_pkg::*;
(
    input  wire logic          i_clk,
    input  wire t_mts_mem_wr   i_wr,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic [31:0]        o_rd_data
);

    logic [31:0] r_mem [NOTE_DEPTH];
    logic [31:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// File: rtl/core/mts_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mts_div: compare divider unit
// Restoring division of CLOCK_HZ by 16*freq, one quotient bit per cycle,
// then clamps quotient-1 into 0..255.
// ----------------------------------------------------------------------------
module mts_div
    import mts_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_mts_div_req i_req,
    output t_mts_div_rsp      o_rsp
);

    localparam logic [CLK_W-1:0] NUM = CLK_W'(CLOCK_HZ);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [CLK_W-1:0]  r_quo;
    logic [7:0]        r_divider;

    logic [DEN_W:0]    rem_sh;
    logic              ge;
    logic [DEN_W:0]    rem_diff;
    logic [CLK_W-1:0]  quo_new;
    logic [CLK_W-1:0]  quo_m1;
    logic [7:0]        clamped;

    // One restoring step
    always_comb begin
        rem_sh   = {r_rem, NUM[r_cnt]};
        ge       = (rem_sh >= {1'b0, r_den});
        rem_diff = rem_sh - {1'b0, r_den};
        quo_new  = {r_quo[CLK_W-2:0], ge};
        quo_m1   = quo_new - CLK_W'(1);
    end

    // Clamp quotient-1 into 0..255
    always_comb begin
        priority if (quo_new == '0) begin
            clamped = 8'd0;
        end else if (quo_new > CLK_W'(256)) begin
            clamped = 8'hFF;
        end else begin
            clamped = quo_m1[7:0];
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= CNT_W'(CLK_W - 1);
            r_rem <= '0;
            r_quo <= '0;
            r_den <= {i_req.freq, 4'd0};
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_rem <= ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo <= quo_new;
            if (r_cnt == '0) begin
                r_divider <= clamped;
            end
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.divider = r_divider;

endmodule
`default_nettype wire

// File: rtl/core/melody_tone_sequencer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// melody_tone_sequencer_unit: buzzer melody sequencer
// Plays melodies held in a 64-entry note memory of (frequency, duration).
// Input channel (i_in_valid / o_in_stall / i_in_data): one transaction per
// operation: a one millisecond tick, a note write, a melody start or an
// enable toggle. Output channel (o_out_valid / i_out_stall / o_out_data):
// exactly one status transaction per input transaction, in order.
//
// One input transaction is worked on at a time. A write, a toggle or an idle
// tick goes straight to S_DONE, which loads the result register; a tick inside
// a note first passes S_TICK, where the elapsed count meets the duration read
// from the note memory. Entering a sounding note (S_ENTER) reads the note
// memory and runs the bit-serial divider (S_DIV) for a start or a note-ending
// tick before S_DONE. The next transaction is accepted while a result
// waits; if the receiver stalls, the result after it waits in the sequencer
// and the input stays stalled. Reset clears the flags, the pointer and the
// elapsed count and sets the enable flag; note memory contents are undefined
// until written.
// ----------------------------------------------------------------------------
module melody_tone_sequencer_unit
    import mts_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_mts_in i_in_data,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_mts_out     o_out_data
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TICK  = 3'd1;
    localparam logic [2:0] S_ENTER = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [15:0]   r_elapsed, n_elapsed;
    logic          r_playing, n_playing;
    logic          r_enable, n_enable;
    logic          r_tone, n_tone;
    logic [7:0]    r_divv, n_divv;
    logic          r_out_valid, n_out_valid;
    t_mts_out      r_out, n_out;

    t_mts_mem_wr   mem_wr;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;
    t_mts_div_req  div_req;
    t_mts_div_rsp  div_rsp;

    logic          in_acc;
    logic          out_free;
    logic [AW-1:0] ptr_next;
    logic [15:0]   elapsed_inc;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign ptr_next   = (r_ptr == AW'(NOTE_DEPTH - 1)) ? '0 : r_ptr + AW'(1);
    assign elapsed_inc = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;

    // Note memory read address
    always_comb begin
        priority if (r_state == S_TICK) begin
            rd_addr = ptr_next;
        end else if (in_acc && i_in_data.operation == OP_START) begin
            rd_addr = mts_addr(i_in_data.note_address);
        end else begin
            rd_addr = r_ptr;
        end
    end

    // Note memory write
    always_comb begin
        mem_wr.en   = in_acc && (i_in_data.operation == OP_WRITE);
        mem_wr.addr = mts_addr(i_in_data.note_address);
        mem_wr.data = {i_in_data.note_frequency, i_in_data.note_duration};
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_elapsed   = r_elapsed;
        n_playing   = r_playing;
        n_enable    = r_enable;
        n_tone      = r_tone;
        n_divv      = r_divv;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        div_req.start = 1'b0;
        div_req.freq  = rd_data[31:16];

        // Result register drains
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.operation)
                        OP_TICK: begin
                            n_state = r_playing ? S_TICK : S_DONE;
                        end
                        OP_WRITE: begin
                            n_state = S_DONE;
                        end
                        OP_START: begin
                            n_ptr   = mts_addr(i_in_data.note_address);
                            n_state = S_ENTER;
                        end
                        OP_TOGGLE: begin
                            n_enable = !r_enable;
                            if (r_enable) begin
                                n_tone = 1'b0;
                                n_divv = 8'd0;
                            end
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            // Current note data is on the read port
            S_TICK: begin
                if (elapsed_inc >= rd_data[15:0]) begin
                    n_tone  = 1'b0;
                    n_divv  = 8'd0;
                    n_ptr   = ptr_next;
                    n_state = S_ENTER;
                end else begin
                    n_elapsed = elapsed_inc;
                    n_state   = S_DONE;
                end
            end
            // Entering the note at the pointer
            S_ENTER: begin
                n_elapsed = 16'd0;
                n_tone    = 1'b0;
                n_divv    = 8'd0;
                if (rd_data == 32'd0) begin
                    n_playing = 1'b0;
                    n_state   = S_DONE;
                end else begin
                    n_playing = 1'b1;
                    if (r_enable && rd_data[31:16] != 16'd0) begin
                        div_req.start = 1'b1;
                        n_state       = S_DIV;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_tone  = 1'b1;
                    n_divv  = div_rsp.divider;
                    n_state = S_DONE;
                end
            end
            // Load the result register once it is free
            S_DONE: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.tone_on         = r_tone;
                    n_out.compare_divider = r_divv;
                    n_out.playing         = r_playing;
                    n_out.buzz_enable     = r_enable;
                    n_out.current_note    = mts_note_field(r_ptr);
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_elapsed   <= '0;
            r_playing   <= 1'b0;
            r_enable    <= 1'b1;
            r_tone      <= 1'b0;
            r_divv      <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_elapsed   <= n_elapsed;
            r_playing   <= n_playing;
            r_enable    <= n_enable;
            r_tone      <= n_tone;
            r_divv      <= n_divv;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    mts_note_mem u_note_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    mts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // A sounding tone needs a melody in progress and the buzzer enabled
    a_tone_needs_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tone |-> (r_playing && r_enable))
        else $error("tone active without playing melody or enable");

    // A silent buzzer reports a zero divider
    a_silent_divider: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_tone |-> (r_divv == 8'd0))
        else $error("nonzero divider while silent");

    // Divider results arrive only while the sequencer waits for them
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    // A result is loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_out_stall) |=> r_state == S_DONE)
        else $error("result produced over a stalled result");

endmodule
`default_nettype wire

// File: verif/tb_melody_tone_sequencer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_melody_tone_sequencer_unit: self-checking bench of the melody sequencer
// A table of directed transactions walks the note, rest, divider, wrap and
// enable corner cases. Random melodies follow: note writes, a start, then
// ticks with toggles and rewrites mixed in, plus some unstructured noise.
// A behavioral copy of the sequencer predicts the status transactions the
// table leaves open; results are compared field by field, in order, while
// the sender idles and the receiver stalls in changing proportions.
// ----------------------------------------------------------------------------
module tb_melody_tone_sequencer_unit
    import mts_pkg::*;
();

    localparam int RAND_ITEMS     = 1500;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;

    // Directed row: transaction plus an optional hand-written status
    typedef struct {
        t_mts_in  item;
        bit       typed;
        t_mts_out status;
    } t_script_row;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    t_mts_in  in_data   = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_mts_out out_data;

    int send_idle_pct = 0;
    int rx_stall_pct  = 0;
    int rand_sent     = 0;
    int mismatches    = 0;
    int stuck_cycles  = 0;

    t_mts_out    status_due [$];
    t_script_row script [$];

    // Predicted sequencer state
    logic [31:0]   melody_mem  [NOTE_DEPTH];
    bit            mem_written [NOTE_DEPTH];
    logic [AW-1:0] note_ptr;
    logic [15:0]   ticks_elapsed;
    bit            playing_now;
    bit            buzzer_on;
    bit            tone_now;
    logic [7:0]    div_now;

    melody_tone_sequencer_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Sequencer prediction
    // ------------------------------------------------------------------
    task automatic clear_sequencer;
        foreach (melody_mem[i]) begin
            melody_mem[i]  = '0;
            mem_written[i] = 1'b0;
        end
        note_ptr      = '0;
        ticks_elapsed = '0;
        playing_now   = 1'b0;
        buzzer_on     = 1'b1;
        tone_now      = 1'b0;
        div_now       = '0;
    endtask

    // Compare divider CLOCK_HZ/(16*f)-1, saturated to 0..255
    task automatic sound_note(input logic [15:0] freq);
        longint quot;
        tone_now = 1'b0;
        div_now  = '0;
        if (buzzer_on && freq != 16'd0) begin
            quot = longint'(CLOCK_HZ) / (longint'(16) * longint'(freq));
            if (quot == 0)
                div_now = '0;
            else if (quot - 1 > 255)
                div_now = 8'd255;
            else
                div_now = 8'(quot - 1);
            tone_now = 1'b1;
        end
    endtask

    // Load the note under the pointer; an all-zero entry ends the melody
    task automatic enter_note;
        ticks_elapsed = '0;
        if (melody_mem[note_ptr] == 32'd0) begin
            playing_now = 1'b0;
            tone_now    = 1'b0;
            div_now     = '0;
        end else begin
            playing_now = 1'b1;
            sound_note(melody_mem[note_ptr][31:16]);
        end
    endtask

    task automatic play_step(input t_mts_in item, output t_mts_out status);
        case (item.operation)
            OP_TICK: begin
                if (playing_now) begin
                    if (ticks_elapsed != 16'hFFFF)
                        ticks_elapsed = ticks_elapsed + 16'd1;
                    if (ticks_elapsed >= melody_mem[note_ptr][15:0]) begin
                        note_ptr = note_ptr + 1'b1;
                        enter_note();
                    end
                end
            end
            OP_WRITE: begin
                melody_mem[item.note_address]  = {item.note_frequency, item.note_duration};
                mem_written[item.note_address] = 1'b1;
            end
            OP_START: begin
                note_ptr = item.note_address;
                enter_note();
            end
            OP_TOGGLE: begin
                buzzer_on = !buzzer_on;
                if (!buzzer_on) begin
                    tone_now = 1'b0;
                    div_now  = '0;
                end
            end
        endcase
        status.tone_on         = tone_now;
        status.compare_divider = div_now;
        status.playing         = playing_now;
        status.buzz_enable     = buzzer_on;
        status.current_note    = 6'(note_ptr);
    endtask

    // True when the transaction would load a note that was never written
    function automatic bit reads_blank(input t_mts_in item, output logic [5:0] addr);
        logic [15:0] next_count;
        bit          hit;
        hit  = 1'b0;
        addr = 6'(note_ptr + 1'b1);
        if (item.operation == OP_START) begin
            addr = item.note_address;
            hit  = !mem_written[addr];
        end else if (item.operation == OP_TICK && playing_now) begin
            next_count = (ticks_elapsed == 16'hFFFF) ? ticks_elapsed : ticks_elapsed + 16'd1;
            hit = next_count >= melody_mem[note_ptr][15:0] && !mem_written[addr];
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_mts_in op_item(input logic [1:0] op, input logic [5:0] addr,
                                        input logic [15:0] freq, input logic [15:0] dur);
        t_mts_in it;
        it.operation      = op;
        it.note_address   = addr;
        it.note_frequency = freq;
        it.note_duration  = dur;
        return it;
    endfunction

    function automatic t_mts_out st(input bit tone, input int div, input bit play,
                                    input bit en, input int note);
        t_mts_out s;
        s.tone_on         = tone;
        s.compare_divider = 8'(div);
        s.playing         = play;
        s.buzz_enable     = en;
        s.current_note    = 6'(note);
        return s;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [5:0] addr,
                           input logic [15:0] freq, input logic [15:0] dur,
                           input bit typed = 1'b0, input t_mts_out status = '0);
        t_script_row row;
        row.item   = op_item(op, addr, freq, dur);
        row.typed  = typed;
        row.status = status;
        script.push_back(row);
    endtask

    // Frequency classes: rest, divider saturating high, audible, saturating low
    function automatic logic [15:0] pick_freq();
        case ($urandom_range(5))
            0:       return 16'd0;
            1:       return 16'($urandom_range(1, 4));
            2:       return 16'($urandom_range(240, 4000));
            3:       return 16'($urandom_range(62500, 65535));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // Mostly short notes, now and then any length
    function automatic logic [15:0] pick_dur();
        if ($urandom_range(15) == 0)
            return 16'($urandom_range(65535));
        return 16'($urandom_range(5));
    endfunction

    function automatic t_mts_in random_note(input logic [5:0] addr, input bit allow_end);
        t_mts_in w;
        w = op_item(OP_WRITE, addr, pick_freq(), pick_dur());
        if (allow_end && $urandom_range(7) == 0) begin
            w.note_frequency = '0;
            w.note_duration  = '0;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Input channel driver
    // ------------------------------------------------------------------
    task automatic send_txn(input t_mts_in item, input bit typed, input t_mts_out typed_status);
        t_mts_out status;
        bit       taken;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        // stall is stable from the falling edge on, so decide acceptance there
        do begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        play_step(item, status);
        status_due.push_back(typed ? typed_status : status);
    endtask

    // Random transaction; a load of a blank entry becomes a write to it
    task automatic send_random(input t_mts_in item);
        logic [5:0] blank;
        if (reads_blank(item, blank))
            item = random_note(blank, 1'b1);
        send_txn(item, 1'b0, '0);
        rand_sent++;
    endtask

    // ------------------------------------------------------------------
    // Output channel: receiver stall and result check
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(negedge clk) begin : result_check
        t_mts_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (status_due.size() == 0) begin
                mismatches++;
                $error("status transaction with nothing pending: %p", out_data);
            end else begin
                want = status_due.pop_front();
                check_field("tone_on", want.tone_on, out_data.tone_on);
                check_field("compare_divider", want.compare_divider, out_data.compare_divider);
                check_field("playing", want.playing, out_data.playing);
                check_field("buzz_enable", want.buzz_enable, out_data.buzz_enable);
                check_field("current_note", want.current_note, out_data.current_note);
            end
        end
    end

    // Watchdog: cycles with no transaction on either channel
    always @(negedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            stuck_cycles = 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stuck_cycles++;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int      base;
        int      len;
        int      pick;
        t_mts_in item;

        clear_sequencer();

        // Directed rows: idle tick, note table, then walk the melody
        add_row(OP_TICK,   6'd0,  16'd0,     16'd0,     1'b1, st(0, 0, 0, 1, 0));
        add_row(OP_WRITE,  6'd0,  16'd1000,  16'd2,     1'b1, st(0, 0, 0, 1, 0));
        add_row(OP_WRITE,  6'd1,  16'd0,     16'd3);             // rest note
        add_row(OP_WRITE,  6'd2,  16'hFFFF,  16'd0);             // zero duration
        add_row(OP_WRITE,  6'd3,  16'd1,     16'hFFFF);          // divider caps at 255
        add_row(OP_WRITE,  6'd4,  16'd0,     16'd0);             // end marker
        add_row(OP_WRITE,  6'd63, 16'd62500, 16'd1);             // 16*f equals the clock
        add_row(OP_START,  6'd0,  16'd0,     16'd0,     1'b1, st(1, 61, 1, 1, 0));
        add_row(OP_TICK,   6'd0,  16'd0,     16'd0);
        add_row(OP_TICK,   6'd0,  16'd0,     16'd0);             // into the rest
        add_row(OP_TOGGLE, 6'd0,  16'd0,     16'd0,     1'b1, st(0, 0, 1, 0, 1));
        add_row(OP_TICK,   6'd0,  16'd0,     16'd0);
        add_row(OP_TICK,   6'd0,  16'd0,     16'd0);
        add_row(OP_TICK,   6'd0,  16'd0,     16'd0);             // next note while disabled
        add_row(OP_TOGGLE, 6'd0,  16'd0,     16'd0,     1'b1, st(0, 0, 1, 1, 2));
        add_row(OP_TICK,   6'd0,  16'd0,     16'd0,     1'b1, st(1, 255, 1, 1, 3));
        add_row(OP_TOGGLE, 6'd0,  16'd0,     16'd0,     1'b1, st(0, 0, 1, 0, 3));
        add_row(OP_TOGGLE, 6'd0,  16'd0,     16'd0,     1'b1, st(0, 0, 1, 1, 3));
        add_row(OP_START,  6'd63, 16'd0,     16'd0,     1'b1, st(1, 0, 1, 1, 63));
        add_row(OP_TICK,   6'd0,  16'd0,     16'd0,     1'b1, st(1, 61, 1, 1, 0));
        add_row(OP_START,  6'd4,  16'd0,     16'd0,     1'b1, st(0, 0, 0, 1, 4));
        add_row(OP_TICK,   6'd0,  16'd0,     16'd0,     1'b1, st(0, 0, 0, 1, 4));
        add_row(OP_WRITE,  6'd63, 16'hFFFF,  16'hFFFF,  1'b1, st(0, 0, 0, 1, 4));
        add_row(OP_START,  6'd63, 16'd0,     16'd0,     1'b1, st(1, 0, 1, 1, 63));
        add_row(OP_TOGGLE, 6'd0,  16'd0,     16'd0,     1'b1, st(0, 0, 1, 0, 63));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_txn(script[i].item, script[i].typed, script[i].status);

        // Random melodies under four idle/stall mixes
        while (rand_sent < RAND_ITEMS) begin
            case (rand_sent * 4 / RAND_ITEMS)
                0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin send_idle_pct = 54; rx_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rx_stall_pct = 54; end
                default: begin send_idle_pct = 24; rx_stall_pct = 24; end
            endcase

            if ($urandom_range(7) == 0) begin
                // unstructured noise, any field value
                item.operation      = 2'($urandom_range(3));
                item.note_address   = 6'($urandom_range(63));
                item.note_frequency = 16'($urandom_range(65535));
                item.note_duration  = 16'($urandom_range(65535));
                send_random(item);
            end else begin
                base = $urandom_range(63);
                len  = $urandom_range(1, 6);
                for (int n = 0; n < len; n++)
                    send_random(random_note(6'(base + n), 1'b0));
                if ($urandom_range(4) != 0)
                    send_random(op_item(OP_WRITE, 6'(base + len), 16'd0, 16'd0));
                send_random(op_item(OP_START, 6'(base), 16'd0, 16'd0));

                // play it out, with toggles, rewrites and restarts mixed in
                for (int t = 0; t < 48 && playing_now; t++) begin
                    pick = $urandom_range(99);
                    if (pick < 5)
                        send_random(op_item(OP_TOGGLE, 6'($urandom_range(63)), 16'd0, 16'd0));
                    else if (pick < 9)
                        send_random(random_note(6'($urandom_range(63)), 1'b1));
                    else if (pick < 11)
                        send_random(op_item(OP_START, 6'($urandom_range(63)), 16'd0, 16'd0));
                    else
                        send_random(op_item(OP_TICK, 6'($urandom_range(63)),
                                            16'($urandom_range(65535)),
                                            16'($urandom_range(65535))));
                end
            end
        end

        in_valid <= 1'b0;
        wait (status_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && status_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
